FILE: rtl/bls_pkg.sv
// Package for the line stepper: command and status structs between the
// controller and the datapath, register map and field widths. No dependencies.
package bls_pkg;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // word index of the color register (paddr[2])
  localparam logic REG_COLOR = 1'b0;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic emit_pix;
    logic emit_err;
  } bls_cmd_t;

  typedef struct packed {
    logic too_big;
    logic cnt_zero;
  } bls_sts_t;

endpackage

FILE: rtl/bls_ctrl.sv
// Line stepper controller: one-hot state machine that sequences load, setup,
// stepping and reject of a line command. Depends on bls_pkg.
module bls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bls_pkg::bls_sts_t sts,
  output bls_pkg::bls_cmd_t cmd,
  output logic              busy
);
  import bls_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_REJ   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.too_big ? ST_REJ : ST_RUN;
      end
      ST_RUN: begin
        cmd.emit_pix = 1'b1;
        cmd.step     = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REJ: begin
        cmd.emit_err = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/bls_dp.sv
// Line stepper datapath: coordinate, span, error-term and count registers,
// plus the registered result stage. Depends on bls_pkg.
module bls_dp #(
  parameter int MAX_SPAN = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bls_pkg::bls_cmd_t             cmd,
  output bls_pkg::bls_sts_t             sts,
  input  logic [bls_pkg::COORD_W-1:0]   start_x,
  input  logic [bls_pkg::COORD_W-1:0]   start_y,
  input  logic [bls_pkg::COORD_W-1:0]   end_x,
  input  logic [bls_pkg::COORD_W-1:0]   end_y,
  input  logic [bls_pkg::COLOR_W-1:0]   color,
  output logic                          out_valid,
  output logic [bls_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [bls_pkg::COORD_W-1:0]   out_pixel_y,
  output logic [bls_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                          out_last_pixel,
  output logic                          out_span_error
);
  import bls_pkg::*;

  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int FRAC_W = SPAN_W + 3;
  localparam logic [COORD_W-1:0] SPAN_LIM = COORD_W'(MAX_SPAN);

  logic [COORD_W-1:0] cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic [COORD_W-1:0] cur_x_nxt, cur_y_nxt;
  logic               negx_r, negy_r, xmaj_r;
  logic [SPAN_W-1:0]  maj_r, min_r, cnt_r;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;

  logic [COORD_W-1:0] dx_d, dy_d, adx_a, ady_a, inc_x, inc_y;
  logic [SPAN_W-1:0]  adx_s, ady_s, maj_s, min_s;
  logic               xmaj_s, frac_pos;
  logic [FRAC_W-1:0]  maj2, min2, frac_init;

  logic               valid_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic [COLOR_W-1:0] pc_r;
  logic               last_r, err_r;

  always_comb begin
    dx_d      = end_x_r - cur_x_r;
    dy_d      = end_y_r - cur_y_r;
    adx_a     = dx_d[COORD_W-1] ? COORD_W'(~dx_d + 1'b1) : dx_d;
    ady_a     = dy_d[COORD_W-1] ? COORD_W'(~dy_d + 1'b1) : dy_d;
    adx_s     = adx_a[SPAN_W-1:0];
    ady_s     = ady_a[SPAN_W-1:0];
    xmaj_s    = (adx_s > ady_s);
    maj_s     = xmaj_s ? adx_s : ady_s;
    min_s     = xmaj_s ? ady_s : adx_s;
    frac_init = {2'b00, min_s, 1'b0} - {3'b000, maj_s};

    sts.too_big  = (adx_a > SPAN_LIM) || (ady_a > SPAN_LIM);
    sts.cnt_zero = (cnt_r == '0);

    maj2     = {2'b00, maj_r, 1'b0};
    min2     = {2'b00, min_r, 1'b0};
    frac_pos = !frac_r[FRAC_W-1];
    inc_x    = negx_r ? '1 : COORD_W'(1);
    inc_y    = negy_r ? '1 : COORD_W'(1);

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (xmaj_r) begin
      cur_x_nxt = cur_x_r + inc_x;
      if (frac_pos) begin
        cur_y_nxt = cur_y_r + inc_y;
      end
    end else begin
      cur_y_nxt = cur_y_r + inc_y;
      if (frac_pos) begin
        cur_x_nxt = cur_x_r + inc_x;
      end
    end
    frac_nxt = frac_pos ? (frac_r - maj2 + min2) : (frac_r + min2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= start_x;
      cur_y_r <= start_y;
      end_x_r <= end_x;
      end_y_r <= end_y;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
    if (cmd.setup) begin
      negx_r <= dx_d[COORD_W-1];
      negy_r <= dy_d[COORD_W-1];
      xmaj_r <= xmaj_s;
      maj_r  <= maj_s;
      min_r  <= min_s;
      cnt_r  <= maj_s;
      frac_r <= frac_init;
    end else if (cmd.step) begin
      cnt_r  <= cnt_r - 1'b1;
      frac_r <= frac_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit_pix || cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      px_r   <= '0;
      py_r   <= '0;
      pc_r   <= '0;
      last_r <= 1'b1;
      err_r  <= 1'b1;
    end else if (cmd.emit_pix) begin
      px_r   <= cur_x_r;
      py_r   <= cur_y_r;
      pc_r   <= color;
      last_r <= sts.cnt_zero;
      err_r  <= 1'b0;
    end
  end

  assign out_valid       = valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pc_r;
  assign out_last_pixel  = last_r;
  assign out_span_error  = err_r;

endmodule

FILE: rtl/bresenham_line_stepper.sv
// Bresenham line stepper top level: APB color register, controller and
// datapath. Depends on bls_pkg, bls_ctrl and bls_dp.
//
// A command is taken when start is high and busy is low. After the load and
// setup steps the stepping loop emits one pixel per clock, start pixel
// first, so a command of major span N yields N + 1 results; a command whose
// span on either axis exceeds MAX_SPAN yields a single result with
// span_error and last_pixel set. Each result is shown for one cycle on
// out_valid, in the cycle after it is formed; the receiver cannot stall
// the stepper.
module bresenham_line_stepper #(
  parameter int MAX_SPAN = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bls_pkg::COORD_W-1:0]   in_start_x,
  input  logic [bls_pkg::COORD_W-1:0]   in_start_y,
  input  logic [bls_pkg::COORD_W-1:0]   in_end_x,
  input  logic [bls_pkg::COORD_W-1:0]   in_end_y,
  output logic                          out_valid,
  output logic [bls_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [bls_pkg::COORD_W-1:0]   out_pixel_y,
  output logic [bls_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                          out_last_pixel,
  output logic                          out_span_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bls_pkg::CFG_AW-1:0]    paddr,
  input  logic [bls_pkg::CFG_DW-1:0]    pwdata,
  output logic [bls_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import bls_pkg::*;

  bls_cmd_t           cmd;
  bls_sts_t           sts;
  logic [COLOR_W-1:0] color_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_COLOR)) begin
      color_r <= pwdata[COLOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLOR) ? {{(CFG_DW-COLOR_W){1'b0}}, color_r} : '0;

  bls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bls_dp #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .start_x         (in_start_x),
    .start_y         (in_start_y),
    .end_x           (in_end_x),
    .end_y           (in_end_y),
    .color           (color_r),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel),
    .out_span_error  (out_span_error)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_error) |-> out_last_pixel)
    else $error("span error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_span_error) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && out_pixel_color == '0))
    else $error("span error result carries pixel data");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_pixel) |-> busy)
    else $error("stepper went idle before the last pixel");

endmodule
